// ===== hw/rtl/spw_pkg.sv =====
// spw_pkg: widths, stage payload types and split multiply helpers for the
// segment/edge-plane wrap test pipeline. No dependencies.
package spw_pkg;

	localparam int COORD_BITS = 20;
	localparam int COORD_FRAC = 4;
	localparam int QUAT_BITS  = 16;
	localparam int QUAT_SLOT  = 16;
	localparam int QF         = QUAT_BITS - 2;
	localparam int TOL_BITS   = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int QP_BITS    = 2 * QUAT_BITS;
	localparam int N_BITS     = 2 * QUAT_BITS + 2;
	localparam int DOT_BITS   = DIFF_BITS + N_BITS + 2;
	localparam int LO_BITS    = DOT_BITS / 2;
	localparam int HI_BITS    = DOT_BITS - LO_BITS;
	localparam int PROD_BITS  = 2 * DOT_BITS;
	localparam int TD_BITS    = TOL_BITS + DOT_BITS + 1;
	localparam int PT_BITS    = 3 * COORD_BITS;
	localparam int ROT_BITS   = 4 * QUAT_SLOT;
	localparam int IN_BITS    = ((3 * PT_BITS + ROT_BITS + 7) / 8) * 8;

	localparam logic signed [N_BITS-1:0] Q_ONE = N_BITS'(1) << (2 * QF);

	localparam logic [1:0] BY_SAME  = 2'd0;
	localparam logic [1:0] BY_PAR   = 2'd1;
	localparam logic [1:0] BY_OUT   = 2'd2;
	localparam logic [1:0] BY_DOWN  = 2'd3;

	typedef logic signed [DOT_BITS-1:0]  dot_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	typedef struct packed {
		dot_t da;
		dot_t dc;
		dot_t dn;
		dot_t u;
		dot_t v;
	} front_t;

	typedef struct packed {
		logic [2*LO_BITS-1:0]             ll;
		logic signed [HI_BITS+LO_BITS:0]  lh;
		logic signed [HI_BITS+LO_BITS:0]  hl;
		logic signed [2*HI_BITS-1:0]      hh;
	} pp_t;

	typedef struct packed {
		prod_t                      pdc;
		prod_t                      pud;
		prod_t                      pnv;
		dot_t                       num;
		dot_t                       den;
		logic signed [TD_BITS-1:0]  tolden;
		logic                       par;
	} wide_t;

	function automatic pp_t part_mul(input dot_t a, input dot_t b);
		logic [LO_BITS-1:0]        al;
		logic [LO_BITS-1:0]        bl;
		logic signed [HI_BITS-1:0] ah;
		logic signed [HI_BITS-1:0] bh;
		pp_t                       r;
		al = a[LO_BITS-1:0];
		bl = b[LO_BITS-1:0];
		ah = a[DOT_BITS-1:LO_BITS];
		bh = b[DOT_BITS-1:LO_BITS];
		r.ll = al * bl;
		r.lh = ah * $signed({1'b0, bl});
		r.hl = bh * $signed({1'b0, al});
		r.hh = ah * bh;
		return r;
	endfunction

	function automatic prod_t pp_sum(input pp_t p);
		prod_t r;
		r = (PROD_BITS'(p.hh) <<< (2 * LO_BITS))
			+ (PROD_BITS'(p.lh) <<< LO_BITS)
			+ (PROD_BITS'(p.hl) <<< LO_BITS)
			+ $signed(PROD_BITS'(p.ll));
		return r;
	endfunction

endpackage

// ===== hw/rtl/spw_front.sv =====
// spw_front: stages 1-3; point differences, quaternion products, plane normal
// and down vector, then the five dot products. Uses spw_pkg.
module spw_front import spw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [PT_BITS-1:0]  point_a,
	input  logic [PT_BITS-1:0]  point_b,
	input  logic [PT_BITS-1:0]  point_c,
	input  logic [ROT_BITS-1:0] edge_rotation,
	output logic                out_valid,
	output front_t              out_data
);

	logic signed [DIFF_BITS-1:0] ab_s1 [3];
	logic signed [DIFF_BITS-1:0] cb_s1 [3];
	logic signed [DIFF_BITS-1:0] ac_s1 [3];
	logic signed [QP_BITS-1:0]   xy_s1, wz_s1, xx_s1, zz_s1, yz_s1, wx_s1, xz_s1, wy_s1, yy_s1;
	logic signed [DIFF_BITS-1:0] ab_s2 [3];
	logic signed [DIFF_BITS-1:0] ac_s2 [3];
	logic signed [DIFF_BITS-1:0] cb_s2 [3];
	logic signed [N_BITS-1:0]    n_s2 [3];
	logic signed [N_BITS-1:0]    d_s2 [3];
	logic                        valid_s1, valid_s2, valid_s3;
	front_t                      data_s3;

	logic signed [QUAT_BITS-1:0] qx, qy, qz, qw;

	assign qx = edge_rotation[0*QUAT_SLOT +: QUAT_BITS];
	assign qy = edge_rotation[1*QUAT_SLOT +: QUAT_BITS];
	assign qz = edge_rotation[2*QUAT_SLOT +: QUAT_BITS];
	assign qw = edge_rotation[3*QUAT_SLOT +: QUAT_BITS];

	function automatic dot_t dot3(
		input logic signed [DIFF_BITS-1:0] x0, x1, x2,
		input logic signed [N_BITS-1:0]    y0, y1, y2
	);
		logic signed [DIFF_BITS+N_BITS-1:0] p0, p1, p2;
		p0 = x0 * y0;
		p1 = x1 * y1;
		p2 = x2 * y2;
		return DOT_BITS'(p0) + DOT_BITS'(p1) + DOT_BITS'(p2);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ab_s1[k] <= DIFF_BITS'($signed(point_a[k*COORD_BITS +: COORD_BITS]))
					- DIFF_BITS'($signed(point_b[k*COORD_BITS +: COORD_BITS]));
				cb_s1[k] <= DIFF_BITS'($signed(point_c[k*COORD_BITS +: COORD_BITS]))
					- DIFF_BITS'($signed(point_b[k*COORD_BITS +: COORD_BITS]));
				ac_s1[k] <= DIFF_BITS'($signed(point_c[k*COORD_BITS +: COORD_BITS]))
					- DIFF_BITS'($signed(point_a[k*COORD_BITS +: COORD_BITS]));
			end
			xy_s1 <= qx * qy;
			wz_s1 <= qw * qz;
			xx_s1 <= qx * qx;
			zz_s1 <= qz * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			xz_s1 <= qx * qz;
			wy_s1 <= qw * qy;
			yy_s1 <= qy * qy;

			ab_s2 <= ab_s1;
			cb_s2 <= cb_s1;
			ac_s2 <= ac_s1;
			n_s2[0] <= (N_BITS'(xy_s1) - N_BITS'(wz_s1)) <<< 1;
			n_s2[1] <= Q_ONE - ((N_BITS'(xx_s1) + N_BITS'(zz_s1)) <<< 1);
			n_s2[2] <= (N_BITS'(yz_s1) + N_BITS'(wx_s1)) <<< 1;
			d_s2[0] <= -((N_BITS'(xz_s1) + N_BITS'(wy_s1)) <<< 1);
			d_s2[1] <= (N_BITS'(wx_s1) - N_BITS'(yz_s1)) <<< 1;
			d_s2[2] <= ((N_BITS'(xx_s1) + N_BITS'(yy_s1)) <<< 1) - Q_ONE;

			data_s3.da <= dot3(ab_s2[0], ab_s2[1], ab_s2[2], n_s2[0], n_s2[1], n_s2[2]);
			data_s3.dc <= dot3(cb_s2[0], cb_s2[1], cb_s2[2], n_s2[0], n_s2[1], n_s2[2]);
			data_s3.dn <= dot3(ac_s2[0], ac_s2[1], ac_s2[2], n_s2[0], n_s2[1], n_s2[2]);
			data_s3.u  <= dot3(ab_s2[0], ab_s2[1], ab_s2[2], d_s2[0], d_s2[1], d_s2[2]);
			data_s3.v  <= dot3(ac_s2[0], ac_s2[1], ac_s2[2], d_s2[0], d_s2[1], d_s2[2]);
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ===== hw/rtl/spw_wide.sv =====
// spw_wide: stages 4-5; sign fold of the denominator, split wide products
// and their recombination. Uses spw_pkg.
module spw_wide import spw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [TOL_BITS-1:0] tol,
	input  logic                in_valid,
	input  front_t              in_data,
	output logic                out_valid,
	output wide_t               out_data
);

	pp_t                       pdc_s4, pud_s4, pnv_s4;
	dot_t                      num_s4, den_s4;
	logic signed [TD_BITS-1:0] tolden_s4;
	logic                      par_s4;
	logic                      valid_s4, valid_s5;
	wide_t                     data_s5;

	dot_t num, den;

	always_comb begin
		if (in_data.dn < 0) begin
			den = -in_data.dn;
			num = in_data.da;
		end else begin
			den = in_data.dn;
			num = -in_data.da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pdc_s4    <= part_mul(in_data.da, in_data.dc);
			pud_s4    <= part_mul(in_data.u, den);
			pnv_s4    <= part_mul(num, in_data.v);
			num_s4    <= num;
			den_s4    <= den;
			tolden_s4 <= $signed({1'b0, tol}) * den;
			par_s4    <= den < $signed(DOT_BITS'({tol, {(2*QF){1'b0}}}));

			data_s5.pdc    <= pp_sum(pdc_s4);
			data_s5.pud    <= pp_sum(pud_s4);
			data_s5.pnv    <= pp_sum(pnv_s4);
			data_s5.num    <= num_s4;
			data_s5.den    <= den_s4;
			data_s5.tolden <= tolden_s4;
			data_s5.par    <= par_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = data_s5;

endmodule

// ===== hw/rtl/segment_plane_wrap_test.sv =====
// segment_plane_wrap_test: top level; tolerance register, pipeline stall
// control and the decision/output stage. Uses spw_pkg, spw_front, spw_wide.
// Path: an input request is registered through stages s1 to s6 to the output request.
// Throughput: one request per cycle; a stall at the output holds every stage.
// Reset (arst_n low, asynchronous): pipeline emptied, tolerance set to 16.
module segment_plane_wrap_test import spw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tolerance_we,
	input  logic [TOL_BITS-1:0] tolerance_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_BITS-1:0]  s_tdata,  // point_a, point_b, point_c, edge_rotation, pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata   // wrapping, decided_by[1:0], pad
);

	logic [TOL_BITS-1:0] tol_q;
	logic                en;
	logic                fr_valid, wd_valid;
	front_t              fr_data;
	wide_t               wd_data;
	logic                valid_s6;
	logic                wrap_s6;
	logic [1:0]          by_s6;

	prod_t lim, num16, den16, tdw, fin_sum;
	logic  wrap;
	logic  [1:0] by;

	assign en       = !valid_s6 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_BITS'(16);
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	spw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.point_a       (s_tdata[PT_BITS-1:0]),
		.point_b       (s_tdata[2*PT_BITS-1:PT_BITS]),
		.point_c       (s_tdata[3*PT_BITS-1:2*PT_BITS]),
		.edge_rotation (s_tdata[3*PT_BITS+ROT_BITS-1:3*PT_BITS]),
		.out_valid     (fr_valid),
		.out_data      (fr_data)
	);

	spw_wide u_wide (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tol       (tol_q),
		.in_valid  (fr_valid),
		.in_data   (fr_data),
		.out_valid (wd_valid),
		.out_data  (wd_data)
	);

	always_comb begin
		lim     = $signed(PROD_BITS'(tol_q) << (COORD_FRAC + 4 * QF));
		num16   = PROD_BITS'(wd_data.num) <<< 4;
		den16   = PROD_BITS'(wd_data.den) <<< 4;
		tdw     = PROD_BITS'(wd_data.tolden);
		fin_sum = wd_data.pud + wd_data.pnv + (tdw <<< (2 * QF));
		if (wd_data.pdc > lim) begin
			wrap = 1'b0;
			by   = BY_SAME;
		end else if (wd_data.par) begin
			wrap = 1'b1;
			by   = BY_PAR;
		end else if ((num16 < -tdw) || (num16 > den16 + tdw)) begin
			wrap = 1'b0;
			by   = BY_OUT;
		end else begin
			wrap = fin_sum > 0;
			by   = BY_DOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= wd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_s6 <= wrap;
			by_s6   <= by;
		end
	end

	assign m_tvalid = valid_s6;
	assign m_tdata  = {5'd0, by_s6, wrap_s6};

endmodule
